// ----- rtl/csk_pkg.sv -----
// Shared types, constants and helpers for the chained-key byte scrambler.
`default_nettype none
package csk_pkg;

  localparam int unsigned KEY_WORDS_DEF = 8;
  localparam int unsigned KEY_WORDS_MAX = 16;
  localparam int unsigned KEY_INIT_LEN  = 8;

  localparam logic OP_SCRAMBLE   = 1'b0;
  localparam logic OP_UNSCRAMBLE = 1'b1;

  localparam logic [7:0] KEY_INIT [KEY_INIT_LEN] = '{
    8'hae, 8'hbf, 8'h56, 8'h78, 8'hab, 8'hcd, 8'hef, 8'hf1
  };

  typedef struct packed {
    logic       op;
    logic [7:0] in_byte;
    logic       last_byte;
  } in_item_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       out_last;
  } out_item_t;

  // Reset value of a key entry; the table repeats for keys longer than eight bytes
  function automatic logic [7:0] key_init(input logic [7:0] idx);
    return KEY_INIT[idx[2:0]];
  endfunction

endpackage
`default_nettype wire

// ----- rtl/chained_key_byte_scrambler.sv -----
// Top level: chained-key byte scrambler, key RAM plus update stage and output register.
//
//  channel | direction | handshake           | payload
//  --------+-----------+---------------------+----------------------------------
//  in_     | request   | in_valid / in_ready | in_data   (op, in_byte, last_byte)
//  out_    | result    | out_valid/out_ready | out_data  (out_byte, out_last)
//
//  One byte per cycle sustained while out_ready stays high; a result passes the
//  update stage and then the output register before out_valid rises.
//  The key RAM read is issued at acceptance, the key update and result are
//  formed from the registered read data in the next cycle, then registered.
//  A write to the entry read at the same edge is forwarded to the next byte.
//  Key entries read as the reset key until first written.
//  A stalled result holds the update stage; the input takes a new request
//  whenever the update stage is empty or moves on.
`default_nettype none
module chained_key_byte_scrambler #(
  parameter int unsigned KEY_WORDS = csk_pkg::KEY_WORDS_DEF
) (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                in_valid,
  output logic                     in_ready,
  input  wire csk_pkg::in_item_t   in_data,
  output logic                     out_valid,
  input  wire logic                out_ready,
  output csk_pkg::out_item_t       out_data
);

  localparam int unsigned IDX_W = (KEY_WORDS > 1) ? $clog2(KEY_WORDS) : 1;

  // message tracking at the input
  logic             in_msg_r, in_msg_nxt;
  logic [7:0]       pos_r, pos_nxt;
  logic [IDX_W-1:0] idx_r, idx_nxt;

  // update stage
  logic              s1_valid_r;
  csk_pkg::in_item_t s1_item_r;
  logic              s1_first_r;
  logic [7:0]        s1_pos_r;
  logic [IDX_W-1:0]  s1_idx_r;
  logic              fwd_r;
  logic [7:0]        fwd_data_r;
  logic [7:0]        prev_r;

  logic               out_valid_r;
  csk_pkg::out_item_t out_item_r;

  logic       in_acc, s1_adv;
  logic [7:0] ram_rd_data, key_old, key_new, res, cipher;
  logic       wr_en;

  assign s1_adv   = s1_valid_r && (!out_valid_r || out_ready);
  assign in_ready = !s1_valid_r || s1_adv;
  assign in_acc   = in_valid && in_ready;

  csk_key_ram #(
    .KEY_WORDS (KEY_WORDS),
    .IDX_W     (IDX_W)
  ) u_key_ram (
    .clk     (clk),
    .rst_n   (rst_n),
    .rd_en   (in_acc),
    .rd_addr (idx_r),
    .wr_en   (wr_en),
    .wr_addr (s1_idx_r),
    .wr_data (key_new),
    .rd_data (ram_rd_data)
  );

  // position and key index; index wraps with the eight-bit position too
  always_comb begin
    in_msg_nxt = in_msg_r;
    pos_nxt    = pos_r;
    idx_nxt    = idx_r;
    if (in_acc) begin
      if (in_data.last_byte) begin
        in_msg_nxt = 1'b0;
        pos_nxt    = '0;
        idx_nxt    = '0;
      end else begin
        in_msg_nxt = 1'b1;
        pos_nxt    = pos_r + 8'd1;
        if (pos_r == 8'hff || idx_r == IDX_W'(KEY_WORDS - 1)) begin
          idx_nxt = '0;
        end else begin
          idx_nxt = idx_r + IDX_W'(1);
        end
      end
    end
  end

  always_comb begin
    key_old = fwd_r ? fwd_data_r : ram_rd_data;
    key_new = (key_old + prev_r) ^ s1_pos_r;
    if (s1_first_r) begin
      res = s1_item_r.in_byte ^ key_old;
    end else if (s1_item_r.op == csk_pkg::OP_SCRAMBLE) begin
      res = (s1_item_r.in_byte - prev_r) ^ key_new;
    end else begin
      res = (s1_item_r.in_byte ^ key_new) + prev_r;
    end
    cipher = (s1_item_r.op == csk_pkg::OP_SCRAMBLE) ? res : s1_item_r.in_byte;
  end

  assign wr_en = s1_adv && !s1_first_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_msg_r    <= 1'b0;
      pos_r       <= '0;
      idx_r       <= '0;
      s1_valid_r  <= 1'b0;
      fwd_r       <= 1'b0;
      prev_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      in_msg_r <= in_msg_nxt;
      pos_r    <= pos_nxt;
      idx_r    <= idx_nxt;
      if (in_acc) begin
        s1_valid_r <= 1'b1;
        // RAM returns the old word when written at the same edge
        fwd_r      <= wr_en && (s1_idx_r == idx_r);
      end else if (s1_adv) begin
        s1_valid_r <= 1'b0;
      end
      if (s1_adv) begin
        prev_r <= cipher;
      end
      if (s1_adv) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_item_r  <= in_data;
      s1_first_r <= !in_msg_r;
      s1_pos_r   <= pos_r;
      s1_idx_r   <= idx_r;
      fwd_data_r <= key_new;
    end
    if (s1_adv) begin
      out_item_r.out_byte <= res;
      out_item_r.out_last <= s1_item_r.last_byte;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_item_r;

endmodule
`default_nettype wire

// ----- rtl/csk_key_ram.sv -----
// Key store: synchronous RAM with registered read and per-entry valid bits.
`default_nettype none
module csk_key_ram #(
  parameter int unsigned KEY_WORDS = csk_pkg::KEY_WORDS_DEF,
  parameter int unsigned IDX_W     = (KEY_WORDS > 1) ? $clog2(KEY_WORDS) : 1
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             rd_en,
  input  wire logic [IDX_W-1:0] rd_addr,
  input  wire logic             wr_en,
  input  wire logic [IDX_W-1:0] wr_addr,
  input  wire logic [7:0]       wr_data,
  output logic      [7:0]       rd_data
);

  logic [7:0]           mem [KEY_WORDS];
  logic [KEY_WORDS-1:0] vld_r;
  logic [7:0]           rd_raw_r;
  logic                 rd_vld_r;
  logic [IDX_W-1:0]     rd_addr_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_raw_r  <= mem[rd_addr];
      rd_addr_r <= rd_addr;
    end
  end

  // valid bits stand in for a clearing sweep of the reset key
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r    <= '0;
      rd_vld_r <= 1'b0;
    end else begin
      if (wr_en) begin
        vld_r[wr_addr] <= 1'b1;
      end
      if (rd_en) begin
        rd_vld_r <= vld_r[rd_addr];
      end
    end
  end

  assign rd_data = rd_vld_r ? rd_raw_r : csk_pkg::key_init(8'(rd_addr_r));

endmodule
`default_nettype wire

// ----- rtl/csk_checker.sv -----
// Port-level checks for the chained-key byte scrambler, bound to the top level.
`default_nettype none
module csk_checker (
  input wire logic               clk,
  input wire logic               rst_n,
  input wire logic               in_valid,
  input wire logic               in_ready,
  input wire csk_pkg::in_item_t  in_data,
  input wire logic               out_valid,
  input wire logic               out_ready,
  input wire csk_pkg::out_item_t out_data
);

  logic [1:0] cnt_r;
  logic       in_acc, out_acc;

  assign in_acc  = in_valid && in_ready;
  assign out_acc = out_valid && out_ready;

  // bytes accepted but not yet delivered
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else begin
      cnt_r <= cnt_r + {1'b0, in_acc} - {1'b0, out_acc};
    end
  end

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result changed or dropped while stalled");

  a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> cnt_r != 2'd0)
    else $error("result shown with no request outstanding");

  a_depth: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r != 2'd3)
    else $error("more requests in flight than pipeline stages");

  a_ready: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r != 2'd2 && cnt_r != 2'd3 |-> in_ready)
    else $error("input blocked with a free stage");

  a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_ready |=> in_valid && $stable(in_data))
    else $error("request changed or withdrawn while waiting");

endmodule

bind chained_key_byte_scrambler csk_checker u_csk_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_ready  (in_ready),
  .in_data   (in_data),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data)
);
`default_nettype wire
